// File: src/chf_pkg.sv
package chf_pkg;

   localparam int CORDIC_STEPS = 16;
   localparam int ATAN_TABLE_LEN = 24;
   localparam int STEPS = (CORDIC_STEPS > ATAN_TABLE_LEN) ? ATAN_TABLE_LEN : CORDIC_STEPS;

   localparam int VEC_W = 36;
   localparam int ACC_W = 33;
   localparam int ANG_W = 18;
   localparam int SUM_W = 19;

   localparam int HALF_TURN = 18000;
   localparam int FULL_TURN = 36000;
   localparam int QUARTER_TURN_FX = 9000 * 65536;
   localparam int ROUND_HALF = 32768;
   localparam int FRAC_BITS = 16;

   typedef logic signed [VEC_W-1:0] vec_type;
   typedef logic signed [ACC_W-1:0] acc_type;
   typedef logic signed [ANG_W-1:0] angle_type;
   typedef logic signed [SUM_W-1:0] sum_type;
   typedef logic signed [15:0] raw_type;

   localparam logic signed [31:0] ATAN_TABLE [ATAN_TABLE_LEN] = '{
      32'sd294912000, 32'sd174096719, 32'sd91987925, 32'sd46694507,
      32'sd23437865, 32'sd11730358, 32'sd5866610, 32'sd2933484,
      32'sd1466764, 32'sd733385, 32'sd366693, 32'sd183346,
      32'sd91673, 32'sd45837, 32'sd22918, 32'sd11459,
      32'sd5730, 32'sd2865, 32'sd1432, 32'sd716,
      32'sd358, 32'sd179, 32'sd90, 32'sd45
   };

endpackage

// File: src/compass_heading_from_field.sv
// Each item passes through stage 0, the CORDIC stages, the rounding stage and the declination stage.
// Throughput: one item per cycle while rsp_tready is high; one register stage per CORDIC step,
// each stage advancing whenever it is empty or the stage after it advances.
// Reset: synchronous, active high; clears all stage valid bits and loads the
// declination register with 1400 (14.00 degrees).
module compass_heading_from_field (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [15:0] axis_x, [31:16] axis_z
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [15:0] heading_centideg
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [15:0] csr_data
);

   localparam int N = chf_pkg::STEPS;
   localparam int NS = N + 3;

   logic [NS-1:0] v_ff;
   logic [NS:0]   adv;

   chf_pkg::raw_type decl_ff;
   chf_pkg::raw_type decl_in;
   chf_pkg::raw_type csr_s;

   chf_pkg::vec_type x_ff [0:N];
   chf_pkg::vec_type z_ff [0:N];
   chf_pkg::acc_type a_ff [0:N];
   logic             zero_ff [0:N];

   chf_pkg::angle_type ang_ff;
   logic [15:0]        head_ff;

   chf_pkg::raw_type in_x;
   chf_pkg::raw_type in_z;
   chf_pkg::vec_type x0_in;
   chf_pkg::vec_type z0_in;
   chf_pkg::acc_type a0_in;
   chf_pkg::vec_type xs;
   chf_pkg::vec_type zs;

   chf_pkg::acc_type   rnd_sum;
   chf_pkg::angle_type rnd;
   chf_pkg::angle_type ang_in;
   chf_pkg::sum_type   h_sum;
   chf_pkg::sum_type   h_in;

   // stage handshake: a stage loads when empty or when its contents move on
   assign adv[NS] = rsp_tready;
   for (genvar k = 0; k < NS; k++) begin : g_adv
      assign adv[k] = ~v_ff[k] | adv[k+1];
   end

   assign req_tready = adv[0];
   assign rsp_tvalid = v_ff[NS-1];
   assign rsp_tdata  = head_ff;
   assign csr_ready  = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         if (adv[0]) begin
            v_ff[0] <= req_tvalid;
         end
         for (int k = 1; k < NS; k++) begin
            if (adv[k]) begin
               v_ff[k] <= v_ff[k-1];
            end
         end
      end
   end

   // declination, saturated on write
   assign csr_s = chf_pkg::raw_type'(csr_data);

   always_comb begin
      if (csr_s > 16'(chf_pkg::HALF_TURN)) begin
         decl_in = 16'(chf_pkg::HALF_TURN);
      end else if (csr_s < -16'sd18000) begin
         decl_in = -16'sd18000;
      end else begin
         decl_in = csr_s;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         decl_ff <= 16'sd1400;
      end else if (csr_valid) begin
         decl_ff <= decl_in;
      end
   end

   // stage 0: scale and pre-rotate into the right half plane
   assign in_x = chf_pkg::raw_type'(req_tdata[15:0]);
   assign in_z = chf_pkg::raw_type'(req_tdata[31:16]);
   assign xs = chf_pkg::vec_type'(in_x) <<< chf_pkg::FRAC_BITS;
   assign zs = chf_pkg::vec_type'(in_z) <<< chf_pkg::FRAC_BITS;

   always_comb begin
      x0_in = xs;
      z0_in = zs;
      a0_in = '0;
      if (in_x < 0) begin
         if (in_z >= 0) begin
            x0_in = zs;
            z0_in = -xs;
            a0_in = chf_pkg::ACC_W'(chf_pkg::QUARTER_TURN_FX);
         end else begin
            x0_in = -zs;
            z0_in = xs;
            a0_in = -chf_pkg::ACC_W'(chf_pkg::QUARTER_TURN_FX);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv[0]) begin
         x_ff[0]    <= x0_in;
         z_ff[0]    <= z0_in;
         a_ff[0]    <= a0_in;
         zero_ff[0] <= (in_x == 0) && (in_z == 0);
      end
   end

   // stages 1..N: one vectoring step each
   for (genvar k = 1; k <= N; k++) begin : g_iter
      chf_pkg::vec_type dx;
      chf_pkg::vec_type dz;
      chf_pkg::acc_type da;
      assign dx = z_ff[k-1] >>> (k - 1);
      assign dz = x_ff[k-1] >>> (k - 1);
      assign da = chf_pkg::ACC_W'(chf_pkg::ATAN_TABLE[k-1]);

      always_ff @(posedge clock) begin
         if (adv[k]) begin
            zero_ff[k] <= zero_ff[k-1];
            if (z_ff[k-1] >= 0) begin
               x_ff[k] <= x_ff[k-1] + dx;
               z_ff[k] <= z_ff[k-1] - dz;
               a_ff[k] <= a_ff[k-1] + da;
            end else begin
               x_ff[k] <= x_ff[k-1] - dx;
               z_ff[k] <= z_ff[k-1] + dz;
               a_ff[k] <= a_ff[k-1] - da;
            end
         end
      end
   end

   // stage N+1: round to centidegrees and clamp
   assign rnd_sum = a_ff[N] + chf_pkg::ACC_W'(chf_pkg::ROUND_HALF);
   assign rnd = chf_pkg::angle_type'(rnd_sum >>> chf_pkg::FRAC_BITS);

   always_comb begin
      if (zero_ff[N]) begin
         ang_in = '0;
      end else if (rnd > chf_pkg::ANG_W'(chf_pkg::HALF_TURN)) begin
         ang_in = chf_pkg::ANG_W'(chf_pkg::HALF_TURN);
      end else if (rnd < -chf_pkg::ANG_W'(chf_pkg::HALF_TURN)) begin
         ang_in = -chf_pkg::ANG_W'(chf_pkg::HALF_TURN);
      end else begin
         ang_in = rnd;
      end
   end

   always_ff @(posedge clock) begin
      if (adv[N+1]) begin
         ang_ff <= ang_in;
      end
   end

   // stage N+2: add declination and wrap
   assign h_sum = chf_pkg::sum_type'(ang_ff) + chf_pkg::sum_type'(decl_ff);

   always_comb begin
      if (h_sum < 0) begin
         h_in = h_sum + chf_pkg::SUM_W'(chf_pkg::FULL_TURN);
      end else if (h_sum > chf_pkg::SUM_W'(chf_pkg::FULL_TURN)) begin
         h_in = h_sum - chf_pkg::SUM_W'(chf_pkg::FULL_TURN);
      end else begin
         h_in = h_sum;
      end
   end

   always_ff @(posedge clock) begin
      if (adv[N+2]) begin
         head_ff <= h_in[15:0];
      end
   end

endmodule
